### rtl/pbpm_pkg.sv
// Shared types, widths and status codes for the packet buffer pool manager.
package pbpm_pkg;

    // Field widths fixed by the interface.
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;
    localparam int LEN_W = 16;
    localparam int ST_W  = 3;

    // Default pool size and reset value of the interrupt reserve register.
    localparam int            POOL_SIZE_DEF   = 16;
    localparam logic [CNT_W-1:0] RESERVE_RESET = 9'd3;

    // Operation codes.
    localparam logic OP_GET     = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [ST_W-1:0] STAT_GRANTED  = 3'd0;
    localparam logic [ST_W-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] STAT_RESERVE  = 3'd2;
    localparam logic [ST_W-1:0] STAT_RELEASED = 3'd3;
    localparam logic [ST_W-1:0] STAT_ALREADY  = 3'd4;
    localparam logic [ST_W-1:0] STAT_INVALID  = 3'd5;

    // One request beat.
    typedef struct packed {
        logic             operation;
        logic             from_interrupt;
        logic [IDX_W-1:0] release_index;
        logic [LEN_W-1:0] requested_length;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] granted_index;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] min_free_count;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request and read the ring head
        logic commit;   // apply the decision and load the result register
    } pbpm_cmd_t;

endpackage

### rtl/pbpm_ctrl.sv
// Controller state machine of the packet buffer pool manager.
module pbpm_ctrl
    import pbpm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output pbpm_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       take;
    logic       commit;

    // The result register is free when empty or being drained this cycle.
    assign take    = s_valid && (state_reg == ST_IDLE);
    assign commit  = (state_reg == ST_DECIDE) && (!out_valid_reg || m_ready);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    assign cmd.capture = take;
    assign cmd.commit  = commit;

    // Next state: wait for a beat, read the ring, then commit the decision.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/pbpm_datapath.sv
// Datapath of the packet buffer pool manager: free ring, free bits and counters.
module pbpm_datapath
    import pbpm_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  pbpm_cmd_t        cmd,
    input  in_beat_t         s_data,
    input  logic             cfg_valid,
    input  logic [CNT_W-1:0] cfg_data,
    output out_beat_t        m_data
);

    localparam int PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [PW-1:0]    PTR_LAST = PW'(POOL_SIZE - 1);
    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SIZE);

    // Free ring and recorded lengths.
    logic [IDX_W-1:0] ring_mem [POOL_SIZE];
    logic [LEN_W-1:0] len_mem  [POOL_SIZE];

    logic [PW-1:0]        head_reg, tail_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     free_reg;
    logic [CNT_W-1:0]     low_reg;
    logic [CNT_W-1:0]     reserve_reg;
    logic [POOL_SIZE-1:0] is_free_reg;
    in_beat_t             req_reg;
    logic [IDX_W-1:0]     rd_reg;
    logic                 rd_fresh_reg;
    out_beat_t            res_reg;

    logic             is_get;
    logic             grant;
    logic             release_ok;
    logic             rel_in_range;
    logic [PW-1:0]    rel_ptr;
    logic [IDX_W-1:0] head_val;
    logic [PW-1:0]    grant_ptr;
    logic [CNT_W-1:0] free_next;
    logic [CNT_W-1:0] low_next;
    logic [ST_W-1:0]  status;

    // A ring slot never written since reset still holds its own position.
    assign head_val  = rd_fresh_reg ? IDX_W'(head_reg) : rd_reg;
    assign grant_ptr = head_val[PW-1:0];

    assign is_get       = (req_reg.operation == OP_GET);
    assign rel_in_range = ({1'b0, req_reg.release_index} < POOL_CNT);
    assign rel_ptr      = req_reg.release_index[PW-1:0];

    // Decision for the captured request.
    always_comb begin
        grant      = 1'b0;
        release_ok = 1'b0;
        if (is_get) begin
            if (free_reg == '0) begin
                status = STAT_EMPTY;
            end else if (req_reg.from_interrupt && (free_reg <= reserve_reg)) begin
                status = STAT_RESERVE;
            end else begin
                status = STAT_GRANTED;
                grant  = 1'b1;
            end
        end else begin
            if (!rel_in_range) begin
                status = STAT_INVALID;
            end else if (is_free_reg[rel_ptr]) begin
                status = STAT_ALREADY;
            end else begin
                status     = STAT_RELEASED;
                release_ok = 1'b1;
            end
        end
    end

    // Count and watermark after this request.
    always_comb begin
        free_next = free_reg;
        low_next  = low_reg;
        if (grant) begin
            free_next = free_reg - 1'b1;
            if (low_reg > free_next) begin
                low_next = free_next;
            end
        end else if (release_ok) begin
            free_next = free_reg + 1'b1;
        end
    end

    // Ring write on release, head read on capture, length record on grant.
    always_ff @(posedge aclk) begin
        if (cmd.commit && release_ok) begin
            ring_mem[tail_reg] <= req_reg.release_index;
        end
        if (cmd.commit && grant) begin
            len_mem[grant_ptr] <= req_reg.requested_length;
        end
        if (cmd.capture) begin
            rd_reg <= ring_mem[head_reg];
        end
    end

    // Request capture, the read-side flag and the result register.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg      <= s_data;
            rd_fresh_reg <= ({1'b0, head_reg} >= fill_reg);
        end
        if (cmd.commit) begin
            res_reg.status         <= status;
            res_reg.granted_index  <= grant ? head_val : '0;
            res_reg.free_count     <= free_next;
            res_reg.min_free_count <= low_next;
        end
    end

    // Pool state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            free_reg    <= POOL_CNT;
            low_reg     <= POOL_CNT;
            is_free_reg <= '1;
        end else if (cmd.commit) begin
            free_reg <= free_next;
            low_reg  <= low_next;
            if (grant) begin
                head_reg               <= (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                is_free_reg[grant_ptr] <= 1'b0;
            end
            if (release_ok) begin
                tail_reg             <= (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                is_free_reg[rel_ptr] <= 1'b1;
                if (fill_reg != POOL_CNT) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    // Reserve register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserve_reg <= RESERVE_RESET;
        end else if (cfg_valid) begin
            reserve_reg <= cfg_data;
        end
    end

    assign m_data = res_reg;

endmodule

### rtl/packet_buffer_pool_manager_top.sv
// A request beat is accepted in the idle state, the registered read of the free ring
// head happens in the read state, and the decide state commits the result once the
// result register is free; a new request is taken only after that commit.
// Reset: synchronous, active low; the ring starts full of indices 0 to
// POOL_SIZE-1 through a fill count, so no clearing pass is needed.
// Top level of the packet buffer pool manager.
module packet_buffer_pool_manager_top
    import pbpm_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_beat_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_beat_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    pbpm_cmd_t cmd;

    // The reserve register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    pbpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pbpm_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

endmodule

### rtl/pbpm_checker.sv
// Port-level checker for the packet buffer pool manager, with its bind.
module pbpm_checker
    import pbpm_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SIZE);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // The watermark never exceeds the current free count.
    a_low_wm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.min_free_count <= m_data.free_count)
        else $error("watermark above free count");

    // The free count stays within the pool.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.free_count <= POOL_CNT)
        else $error("free count beyond pool size");

    // Only a grant carries an index, and a grant names a descriptor of the pool.
    a_grant_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STAT_GRANTED)
                    ? ({1'b0, m_data.granted_index} < POOL_CNT)
                    : (m_data.granted_index == '0))
        else $error("granted index inconsistent with status");

    // An empty-pool refusal reports a zero free count.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_EMPTY) |-> m_data.free_count == '0)
        else $error("empty status with free descriptors");

endmodule

bind packet_buffer_pool_manager_top pbpm_checker #(
    .POOL_SIZE (POOL_SIZE)
) u_pbpm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
